// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("dcm assertion failed");

// Clocked assertion that is also checked during reset.
`define DCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dcm assertion failed");

`endif

// ===== design/dcm_pkg.sv =====
package dcm_pkg;

    // Field widths of the input and result words.
    localparam int unsigned ValueWidth = 8;
    localparam int unsigned IndexWidth = 16;
    localparam int unsigned SumWidth   = 16;
    localparam int unsigned ShiftWidth = 5;

    // Control for one step of the multiply-accumulate stage.
    typedef struct packed {
        logic fire;    // a word leaves the input register this cycle
        logic col_ok;  // column >= disparity for this word
        logic last;    // final channel of the pixel
    } dcm_step_t;

endpackage

// ===== design/dcm_mac.sv =====
`include "assert_macros.svh"

module dcm_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dcm_pkg::dcm_step_t                    step,
    input  logic signed [dcm_pkg::ValueWidth-1:0] left_value,
    input  logic signed [dcm_pkg::ValueWidth-1:0] right_value,
    input  logic        [dcm_pkg::ShiftWidth-1:0] shift_amount,
    output logic signed [dcm_pkg::ValueWidth-1:0] pixel_value
);
    import dcm_pkg::*;

    logic        [SumWidth-1:0] sum_reg;
    logic        [SumWidth-1:0] sum_next;
    logic signed [SumWidth-1:0] product;
    logic        [SumWidth-1:0] sum_add;
    logic signed [SumWidth-1:0] sum_shifted;

    // Signed 8x8 product, accumulated modulo 2^16.
    assign product     = left_value * right_value;
    assign sum_add     = sum_reg + product;
    assign sum_shifted = $signed(sum_add) >>> shift_amount;

    // The pixel is zero when the last word has column below disparity.
    assign pixel_value = step.col_ok ? sum_shifted[ValueWidth-1:0] : '0;

    // Accumulate valid columns and clear at the end of each pixel.
    always_comb begin
        sum_next = sum_reg;
        if (step.fire) begin
            if (step.last) begin
                sum_next = '0;
            end else if (step.col_ok) begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    // A pixel's last word always leaves the accumulator cleared.
    `DCM_ASSERT(a_sum_cleared, aclk, aresetn, step.fire && step.last |=> sum_reg == '0)
    // Non-last words with column below disparity never change the sum.
    `DCM_ASSERT(a_skip_holds, aclk, aresetn,
        step.fire && !step.last && !step.col_ok |=> $stable(sum_reg))
    // Non-last words with a valid column fold their product into the sum.
    `DCM_ASSERT(a_sum_adds, aclk, aresetn,
        step.fire && !step.last && step.col_ok |=> sum_reg == $past(sum_add))

endmodule

// ===== design/disparity_correlation_mac_core.sv =====
// A pixel's last word waits in the input register until the result register is free or being taken.
// Throughput: one word per cycle unless a pixel waits for m_ready; a single 8x8 MAC sets the rate.
// While a finished pixel waits for m_ready, the input register fills if empty and then stalls.
// Reset (aresetn, synchronous, active low) empties both registers, clears the
// running sum and sets the shift amount to zero.
`include "assert_macros.svh"

module disparity_correlation_mac_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic        [dcm_pkg::ShiftWidth-1:0] cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dcm_pkg::ValueWidth-1:0] s_left_value,
    input  logic signed [dcm_pkg::ValueWidth-1:0] s_right_value,
    input  logic        [dcm_pkg::IndexWidth-1:0] s_column,
    input  logic        [dcm_pkg::IndexWidth-1:0] s_disparity,
    input  logic                                  s_last_channel,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dcm_pkg::ValueWidth-1:0] m_pixel_value
);
    import dcm_pkg::*;

    logic [ShiftWidth-1:0]        shift_reg;
    logic                         in_valid_reg;
    logic signed [ValueWidth-1:0] in_left_reg;
    logic signed [ValueWidth-1:0] in_right_reg;
    logic                         in_col_ok_reg;
    logic                         in_last_reg;
    logic                         m_valid_reg;
    logic signed [ValueWidth-1:0] m_pixel_reg;
    logic                         advance;
    dcm_step_t                    step;
    logic signed [ValueWidth-1:0] pixel_next;

    // The pipeline moves whenever the result register is free or being taken.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign step.fire   = in_valid_reg && advance;
    assign step.col_ok = in_col_ok_reg;
    assign step.last   = in_last_reg;

    // Shift amount register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
        end else if (cfg_wr_en) begin
            shift_reg <= cfg_wr_data;
        end
    end

    // Input register; the column check is done here to keep the next stage short.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_left_reg   <= s_left_value;
            in_right_reg  <= s_right_value;
            in_col_ok_reg <= s_column >= s_disparity;
            in_last_reg   <= s_last_channel;
        end
    end

    dcm_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .left_value   (in_left_reg),
        .right_value  (in_right_reg),
        .shift_amount (shift_reg),
        .pixel_value  (pixel_next)
    );

    // Result register, loaded on the last word of a pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step.fire && step.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (step.fire && step.last) begin
            m_pixel_reg <= pixel_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_reg;

    // Reset empties the result register.
    `DCM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid_reg)
    // A new pixel appears only after a last word left the input register.
    `DCM_ASSERT(a_result_from_last, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(in_valid_reg && in_last_reg))
    // A waiting pixel is never overwritten before it is taken.
    `DCM_ASSERT(a_result_held, aclk, aresetn,
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_pixel_reg))
    // An empty result register never blocks the input side.
    `DCM_ASSERT(a_ready_when_free, aclk, aresetn, !m_valid_reg |-> s_ready)

endmodule
